### rtl/annexb_nal_unit_splitter_macros.svh
// Assertion macros shared by the NAL unit splitter RTL.
// Each macro needs clk in the including module's scope; ANXB_ASSERT also rst.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// Checked on every clock edge outside reset.
`define ANXB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ANXB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/anxb_pkg.sv
// Types and constants of the Annex B NAL unit splitter.
// Used by anxb_parser, anxb_out_skid and annexb_nal_unit_splitter; depends on nothing.
package anxb_pkg;

  localparam int DATA_W  = 8;
  localparam int TYPE_W  = 5;
  localparam int FIELD_W = 20;
  localparam int DISP_W  = 2;
  localparam int CFG_W   = 21;

  localparam logic [CFG_W-1:0] MAX_NAL_RESET = 21'd65536;

  // Result dispositions.
  localparam logic [DISP_W-1:0] DISP_SKIP   = 2'd0;
  localparam logic [DISP_W-1:0] DISP_SUBMIT = 2'd1;
  localparam logic [DISP_W-1:0] DISP_RENDER = 2'd2;
  localparam logic [DISP_W-1:0] DISP_ERROR  = 2'd3;

  // NAL unit types that are forwarded.
  localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;
  localparam logic [TYPE_W-1:0] NAL_IDR   = 5'd5;
  localparam logic [TYPE_W-1:0] NAL_SPS   = 5'd7;
  localparam logic [TYPE_W-1:0] NAL_PPS   = 5'd8;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              packet_last;
  } byte_word_t;

  typedef struct packed {
    logic [DISP_W-1:0]  disposition;
    logic [TYPE_W-1:0]  unit_type;
    logic [FIELD_W-1:0] unit_offset;
    logic [FIELD_W-1:0] unit_length;
    logic               packet_end;
  } result_word_t;

  typedef struct packed {
    logic         valid;
    result_word_t word;
  } result_push_t;

endpackage

### rtl/anxb_parser.sv
// Input register and start code parser of the NAL unit splitter.
// Depends on anxb_pkg and the assertion macros header.
`include "annexb_nal_unit_splitter_macros.svh"

module anxb_parser #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  anxb_pkg::byte_word_t           byte_word,
  input  logic [anxb_pkg::CFG_W-1:0]     max_nal_bytes,
  input  logic                           room,
  output anxb_pkg::result_push_t         push
);

  localparam int LB   = LENGTH_BITS;
  localparam int CW   = (LB + 1 > anxb_pkg::CFG_W) ? LB + 1 : anxb_pkg::CFG_W;
  localparam logic [LB-1:0] POS_TOP = '1;

  localparam logic [1:0] PHASE_LEAD    = 2'd0;
  localparam logic [1:0] PHASE_UNIT    = 2'd1;
  localparam logic [1:0] PHASE_DISCARD = 2'd2;

  function automatic logic [anxb_pkg::FIELD_W-1:0] to_field(input logic [LB-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[anxb_pkg::FIELD_W-1:0];
  endfunction

  logic                 s1_valid;
  anxb_pkg::byte_word_t s1_word;

  logic [LB-1:0]               byte_position, byte_position_next;
  logic [1:0]                  zero_run, zero_run_next;
  logic [LB-1:0]               unit_start, unit_start_next;
  logic [anxb_pkg::TYPE_W-1:0] first_byte_type, first_byte_type_next;
  logic                        type_captured, type_captured_next;
  logic [1:0]                  parse_phase, parse_phase_next;

  logic                        accept, advance;
  logic [anxb_pkg::DATA_W-1:0] b;
  logic                        last;
  logic                        pos_sat, start_hit, lead_bad, res_fire;
  logic [LB-1:0]               pos_inc, close_end, len_raw, len;
  logic [anxb_pkg::TYPE_W-1:0] fbt_close, ctype;
  logic [anxb_pkg::DISP_W-1:0] cclass, cdisp;
  logic                        too_big;
  anxb_pkg::result_word_t      close_word, res_word;

  assign accept     = byte_valid & ~byte_stall;
  assign byte_stall = s1_valid & ~room;
  assign advance    = s1_valid & room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_word <= byte_word;
    end
  end

  assign b         = s1_word.data_byte;
  assign last      = s1_word.packet_last;
  assign pos_sat   = (byte_position == POS_TOP);
  assign pos_inc   = pos_sat ? byte_position : byte_position + LB'(1);
  assign start_hit = (b == 8'd1) && zero_run[1];

  // Closing a unit: on a start code the unit ends before the zero run,
  // on the packet's last byte it ends after this byte.
  assign close_end = start_hit ? byte_position - LB'(zero_run) : pos_inc;
  assign len_raw   = (close_end >= unit_start) ? close_end - unit_start : '0;
  assign len       = pos_sat ? POS_TOP : len_raw;
  assign fbt_close = (start_hit || type_captured) ? first_byte_type : b[4:0];
  assign ctype     = (len != '0) ? fbt_close : '0;

  always_comb begin
    case (ctype) inside
      anxb_pkg::NAL_SLICE, anxb_pkg::NAL_IDR: cclass = anxb_pkg::DISP_RENDER;
      anxb_pkg::NAL_SPS, anxb_pkg::NAL_PPS:   cclass = anxb_pkg::DISP_SUBMIT;
      default:                                cclass = anxb_pkg::DISP_SKIP;
    endcase
  end

  assign too_big = (CW'(len) + CW'(3)) > CW'(max_nal_bytes);
  assign cdisp   = (cclass != anxb_pkg::DISP_SKIP && too_big) ? anxb_pkg::DISP_ERROR : cclass;

  always_comb begin
    close_word.disposition = cdisp;
    close_word.unit_type   = ctype;
    close_word.unit_offset = to_field(unit_start);
    close_word.unit_length = to_field(len);
    close_word.packet_end  = last;
  end

  always_comb begin
    byte_position_next   = pos_inc;
    zero_run_next        = zero_run;
    unit_start_next      = unit_start;
    first_byte_type_next = first_byte_type;
    type_captured_next   = type_captured;
    parse_phase_next     = parse_phase;
    lead_bad             = 1'b0;
    res_fire             = 1'b0;
    res_word             = close_word;

    unique case (parse_phase)
      PHASE_LEAD: begin
        if (b == 8'd0 && zero_run != 2'd3) begin
          zero_run_next = zero_run + 2'd1;
          lead_bad      = last;
        end else if (start_hit) begin
          zero_run_next        = 2'd0;
          unit_start_next      = pos_inc;
          type_captured_next   = 1'b0;
          first_byte_type_next = '0;
          parse_phase_next     = PHASE_UNIT;
          if (last) begin
            // The packet is a bare start code: one empty skip result.
            res_fire               = 1'b1;
            res_word.disposition   = anxb_pkg::DISP_SKIP;
            res_word.unit_type     = '0;
            res_word.unit_offset   = to_field(pos_inc);
            res_word.unit_length   = '0;
            res_word.packet_end    = 1'b1;
          end
        end else begin
          lead_bad = 1'b1;
        end
        if (lead_bad) begin
          res_fire             = 1'b1;
          res_word.disposition = anxb_pkg::DISP_ERROR;
          res_word.unit_type   = '0;
          res_word.unit_offset = to_field(byte_position);
          res_word.unit_length = '0;
          res_word.packet_end  = last;
          parse_phase_next     = PHASE_DISCARD;
        end
      end
      PHASE_UNIT: begin
        if (start_hit) begin
          res_fire = 1'b1;
          if (cdisp == anxb_pkg::DISP_ERROR) begin
            parse_phase_next = PHASE_DISCARD;
          end else begin
            unit_start_next      = pos_inc;
            type_captured_next   = 1'b0;
            first_byte_type_next = '0;
          end
          zero_run_next = 2'd0;
        end else begin
          if (!type_captured) begin
            first_byte_type_next = b[4:0];
          end
          type_captured_next = 1'b1;
          if (b == 8'd0) begin
            zero_run_next = (zero_run != 2'd3) ? zero_run + 2'd1 : 2'd3;
          end else begin
            zero_run_next = 2'd0;
          end
          res_fire = last;
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      byte_position_next   = '0;
      zero_run_next        = 2'd0;
      unit_start_next      = '0;
      first_byte_type_next = '0;
      type_captured_next   = 1'b0;
      parse_phase_next     = PHASE_LEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      zero_run        <= 2'd0;
      unit_start      <= '0;
      first_byte_type <= '0;
      type_captured   <= 1'b0;
      parse_phase     <= PHASE_LEAD;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      zero_run        <= zero_run_next;
      unit_start      <= unit_start_next;
      first_byte_type <= first_byte_type_next;
      type_captured   <= type_captured_next;
      parse_phase     <= parse_phase_next;
    end
  end

  assign push.valid = advance & res_fire;
  assign push.word  = res_word;

  `ANXB_ASSERT(a_clear_after_last, (advance && last) |=> (byte_position == '0 && parse_phase == PHASE_LEAD), "packet state not cleared after last byte")
  `ANXB_ASSERT(a_discard_silent, (s1_valid && parse_phase == PHASE_DISCARD) |-> !push.valid, "result produced while discarding")

endmodule

### rtl/anxb_out_skid.sv
// Output register with one skid entry for the NAL unit splitter results.
// Depends on anxb_pkg and the assertion macros header.
`include "annexb_nal_unit_splitter_macros.svh"

module anxb_out_skid (
  input  logic                    clk,
  input  logic                    rst,
  input  anxb_pkg::result_push_t  push,
  output logic                    room,
  output logic                    result_valid,
  input  logic                    result_stall,
  output anxb_pkg::result_word_t  result_word
);

  logic                   out_valid, skid_valid;
  anxb_pkg::result_word_t out_word, skid_word;
  logic                   pop;

  assign pop  = out_valid & ~result_stall;
  assign room = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (push.valid) begin
      if (out_valid && !pop) begin
        skid_word <= push.word;
      end else begin
        out_word <= push.word;
      end
    end
  end

  assign result_valid = out_valid;
  assign result_word  = out_word;

  `ANXB_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry held without an output word")
  `ANXB_ASSERT(a_no_push_when_full, push.valid |-> !skid_valid, "word pushed into a full skid")
  `ANXB_ASSERT(a_skid_drains, (skid_valid && pop) |=> (!skid_valid && out_valid), "skid entry not moved on pop")

endmodule

### rtl/annexb_nal_unit_splitter.sv
// H.264 Annex B NAL unit splitter: top level with the limit register.
// Depends on anxb_pkg, anxb_parser and anxb_out_skid.
//
// Usage. Packet bytes enter one word at a time on the byte channel
// (byte_valid, byte_stall, byte_word); packet_last marks each packet's
// final byte. Results leave on the result channel (result_valid,
// result_stall, result_word), at most one per byte: a closed NAL unit with
// its disposition, type, offset and length, or a packet error.
// The cfg channel writes max_nal_bytes; it is always ready. The user must
// write it only while no byte is in flight; the block does not enforce it.
// A result passes the input register, then the output register or the skid
// entry. Throughput: one byte per cycle while the output side has room, set
// by the single parser stage whose state (zero run, positions, phase)
// updates once per byte. Reset clears the parser to expect a leading start
// code at offset zero, empties the input register, output register and skid
// entry, and loads max_nal_bytes with 65536.
// When the receiver stalls, the current result holds and one more result
// is kept in a skid entry; byte_stall rises only once that entry is full,
// and it never depends combinationally on result_stall.
module annexb_nal_unit_splitter #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_stall,
  input  anxb_pkg::byte_word_t       byte_word,
  output logic                       result_valid,
  input  logic                       result_stall,
  output anxb_pkg::result_word_t     result_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [anxb_pkg::CFG_W-1:0] cfg_data
);

  // The unit size limit is the one configuration register.
  logic [anxb_pkg::CFG_W-1:0] max_nal_bytes;
  logic                       room;
  anxb_pkg::result_push_t     push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nal_bytes <= anxb_pkg::MAX_NAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_nal_bytes <= cfg_data;
    end
  end

  // Parser: registers the incoming word and turns it into at most one
  // result, moving it on whenever the output side has room.
  anxb_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .max_nal_bytes(max_nal_bytes),
    .room         (room),
    .push         (push)
  );

  // Output register plus skid entry decouples the receiver's stall.
  anxb_out_skid u_out_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word (result_word)
  );

endmodule
